>>> sv/tfl_pkg.sv
// Shared types and constants for the TLV field lookup block.
`timescale 1ns / 1ps

package tfl_pkg;

   localparam int MAX_NAME_BYTES = 8;
   localparam int MESSAGE_POSITION_BITS = 16;

   localparam logic [3:0] NAME_LIMIT = 4'((MAX_NAME_BYTES < 8) ? MAX_NAME_BYTES : 8);
   localparam logic [2:0] KIND_INTEGER = 3'd2;
   localparam logic [7:0] KIND_LIMIT = 8'd6;

   localparam logic [1:0] CSR_TARGET_TYPE = 2'd0;
   localparam logic [1:0] CSR_TARGET_NAME_LENGTH = 2'd1;
   localparam logic [1:0] CSR_TARGET_NAME = 2'd2;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_TYPE    = 3'd1,
      PH_NAMELEN = 3'd2,
      PH_DLEN    = 3'd3,
      PH_NAME    = 3'd4,
      PH_DATA    = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [63:0] field_value;
      logic [15:0] data_offset;
      logic [15:0] data_length;
      logic        status;
   } rsp_type;

endpackage

>>> sv/tlv_field_lookup_top.sv
// TLV field lookup: byte-stream parser that finds one configured field per message.
//
// Usage:
//   req channel: one message byte per beat (data_byte, last_byte). The first four
//   bytes are a header; fields follow as type, name length, 32-bit big-endian data
//   length, name and data. Each byte is parsed in the cycle it is accepted, so one
//   byte per cycle is sustained while req_stall is low.
//   rsp channel: one result beat per message, built from the beat that carries
//   last_byte and registered: found, field_value, data_offset, data_length, status.
//   csr channel: index 0 target_type, 1 target_name_length, 2 target_name; always
//   ready, write only between messages.
//   Results go through an output register backed by a one-entry skid register, so
//   bytes keep flowing while a result waits. req_stall rises only when both hold a
//   result, i.e. a second message finished while rsp_stall held the first.
//   Reset (synchronous) clears the parser to the header phase, empties the result
//   registers and sets target_type to integer, empty name.
`timescale 1ns / 1ps

module tlv_field_lookup_top #(
   parameter int MESSAGE_POSITION_BITS = tfl_pkg::MESSAGE_POSITION_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tfl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tfl_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_wdata
);

   localparam int PosBits = MESSAGE_POSITION_BITS;

   logic [2:0]  target_type_ff;
   logic [3:0]  target_name_length_ff;
   logic [63:0] target_name_ff;

   tfl_pkg::phase_type phase_ff, phase_in;
   logic [PosBits-1:0] pos_ff, pos_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  namelen_ff, namelen_in;
   logic [31:0] dlen_ff, dlen_in;
   logic        nsm_ff, nsm_in;
   logic [63:0] acc_ff, acc_in;
   logic        match_ff, match_in;
   logic [15:0] moff_ff, moff_in;
   logic [15:0] mlen_ff, mlen_in;
   logic [2:0]  name_idx_ff, name_idx_in;
   logic [3:0]  data_idx_ff, data_idx_in;

   logic        out_valid_ff, skid_valid_ff;
   tfl_pkg::rsp_type out_ff, skid_ff, result;

   logic        req_accept, res_fire, out_take;
   logic [7:0]  b;
   logic [31:0] dlen_shift, fin_dlen, pos_wide;
   logic        hdr_end, dlen_end, name_end, data_end, finish, nsm_pre;
   logic [15:0] pos_sat;

   assign csr_ready  = 1'b1;
   assign req_stall  = skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_ff;
   assign req_accept = req_valid && !req_stall;
   assign res_fire   = req_accept && req_data.last_byte;
   assign out_take   = out_valid_ff && !rsp_stall;
   assign b          = req_data.data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_type_ff        <= 3'd2;
         target_name_length_ff <= 4'd0;
         target_name_ff        <= 64'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tfl_pkg::CSR_TARGET_TYPE:        target_type_ff <= csr_wdata[2:0];
            tfl_pkg::CSR_TARGET_NAME_LENGTH: target_name_length_ff <= csr_wdata[3:0];
            tfl_pkg::CSR_TARGET_NAME:        target_name_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // per-byte decode helpers
   assign pos_in     = (pos_ff == '1) ? pos_ff : pos_ff + PosBits'(1);
   assign pos_wide   = 32'(pos_in);
   assign pos_sat    = (pos_wide > 32'h0000_FFFF) ? 16'hFFFF : pos_wide[15:0];
   assign dlen_shift = {dlen_ff[23:0], b};
   assign hdr_end    = (phase_ff == tfl_pkg::PH_HEADER) && (cnt_ff == 32'd3);
   assign dlen_end   = (phase_ff == tfl_pkg::PH_DLEN) && (cnt_ff == 32'd3);
   assign name_end   = (phase_ff == tfl_pkg::PH_NAME) && (cnt_ff == 32'd1);
   assign data_end   = (phase_ff == tfl_pkg::PH_DATA) && (cnt_ff == 32'd1);
   assign finish     = (dlen_end && (namelen_ff == 8'd0)) || name_end;
   assign fin_dlen   = dlen_end ? dlen_shift : dlen_ff;
   assign nsm_pre    = (phase_ff == tfl_pkg::PH_NAME)
                       ? (nsm_ff && (target_name_ff[{name_idx_ff, 3'b000} +: 8] == b))
                       : nsm_ff;

   // next phase
   always_comb begin
      case (phase_ff)
         tfl_pkg::PH_HEADER:  phase_in = hdr_end ? tfl_pkg::PH_TYPE : tfl_pkg::PH_HEADER;
         tfl_pkg::PH_TYPE:    phase_in = tfl_pkg::PH_NAMELEN;
         tfl_pkg::PH_NAMELEN: phase_in = tfl_pkg::PH_DLEN;
         tfl_pkg::PH_DLEN: begin
            if (!dlen_end) begin
               phase_in = tfl_pkg::PH_DLEN;
            end else if (namelen_ff != 8'd0) begin
               phase_in = tfl_pkg::PH_NAME;
            end else begin
               phase_in = (fin_dlen != 32'd0) ? tfl_pkg::PH_DATA : tfl_pkg::PH_TYPE;
            end
         end
         tfl_pkg::PH_NAME: begin
            if (!name_end) begin
               phase_in = tfl_pkg::PH_NAME;
            end else begin
               phase_in = (fin_dlen != 32'd0) ? tfl_pkg::PH_DATA : tfl_pkg::PH_TYPE;
            end
         end
         tfl_pkg::PH_DATA: phase_in = data_end ? tfl_pkg::PH_TYPE : tfl_pkg::PH_DATA;
         default:          phase_in = tfl_pkg::PH_HEADER;
      endcase
   end

   // next datapath values
   always_comb begin
      cnt_in      = cnt_ff;
      kind_in     = kind_ff;
      namelen_in  = namelen_ff;
      dlen_in     = dlen_ff;
      nsm_in      = nsm_pre;
      acc_in      = acc_ff;
      match_in    = match_ff;
      moff_in     = moff_ff;
      mlen_in     = mlen_ff;
      name_idx_in = (phase_ff == tfl_pkg::PH_NAME) ? name_idx_ff + 3'd1 : 3'd0;
      data_idx_in = 4'd0;
      case (phase_ff)
         tfl_pkg::PH_HEADER: begin
            cnt_in = hdr_end ? 32'd0 : cnt_ff + 32'd1;
         end
         tfl_pkg::PH_TYPE: begin
            kind_in = (b > tfl_pkg::KIND_LIMIT) ? 3'd0 : b[2:0];
         end
         tfl_pkg::PH_NAMELEN: begin
            namelen_in = b;
            nsm_in     = !match_ff && (kind_ff == target_type_ff)
                         && (b == {4'd0, target_name_length_ff})
                         && (target_name_length_ff <= tfl_pkg::NAME_LIMIT);
            cnt_in     = 32'd0;
            dlen_in    = 32'd0;
         end
         tfl_pkg::PH_DLEN: begin
            dlen_in = dlen_shift;
            cnt_in  = cnt_ff + 32'd1;
            if (dlen_end && (namelen_ff != 8'd0)) begin
               cnt_in = {24'd0, namelen_ff};
            end
         end
         tfl_pkg::PH_NAME: begin
            cnt_in = cnt_ff - 32'd1;
         end
         tfl_pkg::PH_DATA: begin
            data_idx_in = (data_idx_ff == 4'd8) ? data_idx_ff : data_idx_ff + 4'd1;
            if (nsm_ff && (kind_ff == tfl_pkg::KIND_INTEGER) && !data_idx_ff[3]) begin
               acc_in[{data_idx_ff[2:0], 3'b000} +: 8] =
                  acc_ff[{data_idx_ff[2:0], 3'b000} +: 8] | b;
            end
            cnt_in = cnt_ff - 32'd1;
            if (data_end) begin
               nsm_in = 1'b0;
            end
         end
         default: ;
      endcase
      if (finish) begin
         if (nsm_pre && !match_ff) begin
            match_in = 1'b1;
            moff_in  = pos_sat;
            mlen_in  = (fin_dlen[31:16] != 16'd0) ? 16'hFFFF : fin_dlen[15:0];
            acc_in   = 64'd0;
         end else begin
            nsm_in = 1'b0;
         end
         if (fin_dlen != 32'd0) begin
            cnt_in = fin_dlen;
         end else begin
            nsm_in = 1'b0;
         end
      end
   end

   always_comb begin
      result.found       = match_in;
      result.field_value = match_in ? acc_in : 64'd0;
      result.data_offset = match_in ? moff_in : 16'd0;
      result.data_length = match_in ? mlen_in : 16'd0;
      result.status      = (phase_in != tfl_pkg::PH_TYPE);
   end

   always_ff @(posedge clock) begin
      if (reset || res_fire) begin
         phase_ff    <= tfl_pkg::PH_HEADER;
         pos_ff      <= '0;
         cnt_ff      <= 32'd0;
         kind_ff     <= 3'd0;
         namelen_ff  <= 8'd0;
         dlen_ff     <= 32'd0;
         nsm_ff      <= 1'b0;
         acc_ff      <= 64'd0;
         match_ff    <= 1'b0;
         moff_ff     <= 16'd0;
         mlen_ff     <= 16'd0;
         name_idx_ff <= 3'd0;
         data_idx_ff <= 4'd0;
      end else if (req_accept) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         cnt_ff      <= cnt_in;
         kind_ff     <= kind_in;
         namelen_ff  <= namelen_in;
         dlen_ff     <= dlen_in;
         nsm_ff      <= nsm_in;
         acc_ff      <= acc_in;
         match_ff    <= match_in;
         moff_ff     <= moff_in;
         mlen_ff     <= mlen_in;
         name_idx_ff <= name_idx_in;
         data_idx_ff <= data_idx_in;
      end
   end

   // result register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (res_fire) begin
         if (out_valid_ff && !out_take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (res_fire) begin
         if (out_valid_ff && !out_take) begin
            skid_ff <= result;
         end else begin
            out_ff <= result;
         end
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without output entry");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      res_fire |=> rsp_valid)
      else $error("no result after last byte");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |->
         (rsp_data.field_value == 64'd0 && rsp_data.data_offset == 16'd0
          && rsp_data.data_length == 16'd0))
      else $error("result fields set without a match");

   a_no_match_in_header: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == tfl_pkg::PH_HEADER) |-> !match_ff)
      else $error("match recorded during header");

endmodule
